### src/spa_pkg.sv
// Shared types, piece-kind codes and line-geometry helpers for the sliding
// attack pipeline. No dependencies.
package spa_pkg;

    localparam logic [1:0] KIND_BISHOP = 2'd0;
    localparam logic [1:0] KIND_ROOK   = 2'd1;
    localparam logic [1:0] KIND_QUEEN  = 2'd2;

    localparam logic [1:0] LINE_DIAG = 2'd0;
    localparam logic [1:0] LINE_ANTI = 2'd1;
    localparam logic [1:0] LINE_RANK = 2'd2;
    localparam logic [1:0] LINE_FILE = 2'd3;

    localparam int NUM_LINES = 4;

    typedef logic [63:0] board_t;

    typedef struct packed {
        logic [1:0]                   action;
        logic [NUM_LINES-1:0][63:0]   mask;
        logic [NUM_LINES-1:0][63:0]   occ;
        logic [NUM_LINES-1:0][63:0]   bit_fwd;
        logic [NUM_LINES-1:0][63:0]   bit_bwd;
    } mask_stage_t;

    typedef struct packed {
        logic [1:0]                   action;
        logic [NUM_LINES-1:0][63:0]   mask;
        logic [NUM_LINES-1:0][63:0]   line_x;
    } sub_stage_t;

    function automatic board_t bit_reverse(input board_t x);
        board_t y;
        for (int n = 0; n < 64; n++)
        begin
            y[n] = x[63-n];
        end
        return y;
    endfunction

    function automatic board_t line_mask(input logic [5:0] sq, input logic [1:0] kind);
        board_t     m;
        logic [2:0] r0;
        logic [2:0] f0;
        logic [2:0] r;
        logic [2:0] f;
        logic [5:0] nb;
        logic       on;
        r0 = sq[5:3];
        f0 = sq[2:0];
        m  = '0;
        for (int n = 0; n < 64; n++)
        begin
            nb = 6'(n);
            r  = nb[5:3];
            f  = nb[2:0];
            case (kind)
                LINE_DIAG: on = ({1'b0, r} + {1'b0, f0}) == ({1'b0, r0} + {1'b0, f});
                LINE_ANTI: on = ({1'b0, r} + {1'b0, f}) == ({1'b0, r0} + {1'b0, f0});
                LINE_RANK: on = (r == r0);
                LINE_FILE: on = (f == f0);
                default:   on = 1'b0;
            endcase
            m[n] = on && (nb != sq);
        end
        return m;
    endfunction

endpackage

### src/spa_mask_stage.sv
// First pipeline stage: derives the four line masks, masked occupancy and the
// doubled piece bits in both bit orders. Depends on spa_pkg.
module spa_mask_stage
    import spa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  logic [1:0]  action,
    input  logic [5:0]  square,
    input  logic [63:0] occupancy,
    output logic        dn_valid,
    input  logic        dn_ready,
    output mask_stage_t dn_data
);

    logic        valid_reg;
    mask_stage_t data_reg;
    mask_stage_t data_next;
    board_t      piece;
    board_t      line_m;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        piece  = board_t'(1) << square;
        line_m = '0;
        data_next.action = action;
        for (int k = 0; k < NUM_LINES; k++)
        begin
            line_m               = line_mask(square, 2'(k));
            data_next.mask[k]    = line_m;
            data_next.occ[k]     = occupancy & line_m;
            data_next.bit_fwd[k] = piece << 1;
            data_next.bit_bwd[k] = bit_reverse(piece) << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // hold payload while the stage is blocked
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### src/spa_sub_stage.sv
// Second pipeline stage: forward and reversed subtractions per line, folded
// together by exclusive or. Depends on spa_pkg.
module spa_sub_stage
    import spa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  mask_stage_t up_data,
    output logic        dn_valid,
    input  logic        dn_ready,
    output sub_stage_t  dn_data
);

    logic       valid_reg;
    sub_stage_t data_reg;
    sub_stage_t data_next;
    board_t     fwd;
    board_t     bwd;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        fwd = '0;
        bwd = '0;
        data_next.action = up_data.action;
        for (int k = 0; k < NUM_LINES; k++)
        begin
            fwd                 = up_data.occ[k] - up_data.bit_fwd[k];
            bwd                 = bit_reverse(up_data.occ[k]) - up_data.bit_bwd[k];
            data_next.mask[k]   = up_data.mask[k];
            data_next.line_x[k] = fwd ^ bit_reverse(bwd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### src/spa_merge_stage.sv
// Final pipeline stage: masks each line, merges by piece kind and holds the
// result register. Depends on spa_pkg.
module spa_merge_stage
    import spa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  sub_stage_t  up_data,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [63:0] attacks
);

    logic   valid_reg;
    board_t attacks_reg;
    board_t attacks_next;
    board_t diag;
    board_t ortho;

    assign up_ready  = !valid_reg || !res_stall;
    assign res_valid = valid_reg;
    assign attacks   = attacks_reg;

    always_comb
    begin
        diag  = (up_data.line_x[LINE_DIAG] & up_data.mask[LINE_DIAG])
              | (up_data.line_x[LINE_ANTI] & up_data.mask[LINE_ANTI]);
        ortho = (up_data.line_x[LINE_RANK] & up_data.mask[LINE_RANK])
              | (up_data.line_x[LINE_FILE] & up_data.mask[LINE_FILE]);
        case (up_data.action)
            KIND_BISHOP: attacks_next = diag;
            KIND_ROOK:   attacks_next = ortho;
            KIND_QUEEN:  attacks_next = diag | ortho;
            default:     attacks_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            attacks_reg <= attacks_next;
        end
    end

endmodule

### src/sliding_piece_attack_sets_core.sv
// Sliding-piece attack sets: three register stages (masks, subtractions, merge).
// Requests pass the mask, subtraction and merge registers in order; each stage
// refills as its successor drains: one request per cycle while res_stall is low.
// Reset: rst_n clears the stage valid bits only; no other state.
// Depends on spa_pkg, spa_mask_stage, spa_sub_stage, spa_merge_stage.
module sliding_piece_attack_sets_core
    import spa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  action,
    input  logic [5:0]  square,
    input  logic [63:0] occupancy,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [63:0] attacks
);

    logic        s1_ready;
    logic        s1_valid;
    mask_stage_t s1_data;
    logic        s2_ready;
    logic        s2_valid;
    sub_stage_t  s2_data;
    logic        s3_ready;

    assign req_stall = !s1_ready;

    spa_mask_stage u_mask
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (req_valid),
        .up_ready  (s1_ready),
        .action    (action),
        .square    (square),
        .occupancy (occupancy),
        .dn_valid  (s1_valid),
        .dn_ready  (s2_ready),
        .dn_data   (s1_data)
    );

    spa_sub_stage u_sub
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s2_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s3_ready),
        .dn_data  (s2_data)
    );

    spa_merge_stage u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s2_valid),
        .up_ready  (s3_ready),
        .up_data   (s2_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .attacks   (attacks)
    );

endmodule

### verif/sliding_piece_attack_sets_core_test.sv
// Self-checking bench for sliding_piece_attack_sets_core: directed then random requests under
// bursty sending and patterned result stalls, each result checked against a local attack model.
// Depends on spa_pkg and the core RTL.
module sliding_piece_attack_sets_core_test;
    import spa_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int RANDOM_REQUESTS = 1430;
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_CYCLES     = 80;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        logic [1:0] action;
        logic [5:0] square;
        board_t     occupancy;
        bit         wait_idle;
    } request_t;

    typedef struct {
        logic [1:0] action;
        logic [5:0] square;
        board_t     occupancy;
        board_t     attacks;
    } attack_record_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  action    = KIND_BISHOP;
    logic [5:0]  square    = 6'd0;
    logic [63:0] occupancy = 64'd0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [63:0] attacks;

    request_t       queued_requests[$];
    attack_record_t pending_attacks[$];

    logic req_taken = 1'b0;
    int   requests_taken = 0;
    int   failures = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    int   holds_done = 0;
    int   segment_left = 0;
    int   stall_mode = 0;

    sliding_piece_attack_sets_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .action    (action),
        .square    (square),
        .occupancy (occupancy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .attacks   (attacks)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic board_t mirror(input board_t x);
        board_t y;
        y = '0;
        for (int n = 0; n < 64; n++)
        begin
            y = {y[62:0], x[n]};
        end
        return y;
    endfunction

    function automatic board_t line_through(input logic [5:0] sq, input logic [1:0] line);
        board_t m;
        int     rank0;
        int     file0;
        int     rk;
        int     fl;
        bit     on_line;
        m     = '0;
        rank0 = int'(sq[5:3]);
        file0 = int'(sq[2:0]);
        for (int n = 0; n < 64; n++)
        begin
            rk = n / 8;
            fl = n % 8;
            case (line)
                LINE_DIAG: on_line = (rk - fl) == (rank0 - file0);
                LINE_ANTI: on_line = (rk + fl) == (rank0 + file0);
                LINE_RANK: on_line = rk == rank0;
                default:   on_line = fl == file0;
            endcase
            if (on_line && n != int'(sq))
                m[n] = 1'b1;
        end
        return m;
    endfunction

    function automatic board_t line_attacks(input logic [5:0] sq, input board_t occ,
                                            input logic [1:0] line);
        board_t m;
        board_t piece;
        board_t blockers;
        board_t upward;
        board_t downward;
        m        = line_through(sq, line);
        piece    = 64'd1 << sq;
        blockers = occ & m;
        upward   = blockers - (piece << 1);
        downward = mirror(mirror(blockers) - (mirror(piece) << 1));
        return (upward ^ downward) & m;
    endfunction

    function automatic board_t attacked_squares(input logic [1:0] kind, input logic [5:0] sq,
                                                input board_t occ);
        board_t a;
        a = '0;
        if (kind == KIND_BISHOP || kind == KIND_QUEEN)
            a |= line_attacks(sq, occ, LINE_DIAG) | line_attacks(sq, occ, LINE_ANTI);
        if (kind == KIND_ROOK || kind == KIND_QUEEN)
            a |= line_attacks(sq, occ, LINE_RANK) | line_attacks(sq, occ, LINE_FILE);
        return a;
    endfunction

    function automatic logic [1:0] random_kind();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return KIND_NONE;
        else if (pick < 7)
            return KIND_BISHOP;
        else if (pick < 13)
            return KIND_ROOK;
        return KIND_QUEEN;
    endfunction

    function automatic board_t random_board();
        board_t a;
        board_t b;
        board_t c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return a & b & c;
            1:       return a & b;
            2:       return a;
            3:       return a | b;
            4:       return a | b | c;
            default: return (64'd1 << $urandom_range(0, 63)) | (a & b & c & {$urandom, $urandom});
        endcase
    endfunction

    task automatic add_request(input logic [1:0] kind, input logic [5:0] sq, input board_t occ,
                               input bit wait_idle);
        request_t r;
        r.action    = kind;
        r.square    = sq;
        r.occupancy = occ;
        r.wait_idle = wait_idle;
        queued_requests.push_back(r);
    endtask

    // hold the payload until the request is taken; then gap or offer the next one
    always @(negedge clk)
    begin : drive_requests
        request_t next_req;
        logic     offer;
        if (rst_n && (!req_valid || req_taken))
        begin
            offer = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (queued_requests.size() != 0
                     && !(queued_requests[0].wait_idle && pending_attacks.size() != 0))
            begin
                next_req = queued_requests.pop_front();
                action    <= next_req.action;
                square    <= next_req.square;
                occupancy <= next_req.occupancy;
                offer = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            req_valid <= offer;
        end
    end

    always @(negedge clk)
    begin : drive_result_stall
        logic hold;
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                hold = 1'b1;
            end
            else if (holds_done < 2 && requests_taken >= 400 + 700 * holds_done)
            begin
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                hold = 1'b1;
            end
            else
            begin
                if (segment_left == 0)
                begin
                    stall_mode   = $urandom_range(0, 3);
                    segment_left = $urandom_range(16, 96);
                end
                segment_left--;
                case (stall_mode)
                    0:       hold = 1'b0;
                    1:       hold = ($urandom_range(0, 3) == 0);
                    2:       hold = ($urandom_range(0, 9) < 7);
                    default: hold = $urandom_range(0, 1);
                endcase
            end
            res_stall <= hold;
        end
    end

    always @(posedge clk)
    begin : watch_ports
        attack_record_t want;
        attack_record_t taken;
        if (rst_n)
        begin
            req_taken <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                taken.action    = action;
                taken.square    = square;
                taken.occupancy = occupancy;
                taken.attacks   = attacked_squares(action, square, occupancy);
                pending_attacks.push_back(taken);
                requests_taken++;
            end
            if (res_valid && !res_stall)
            begin
                if (pending_attacks.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected result: attacks %h", attacks);
                end
                else
                begin
                    want = pending_attacks.pop_front();
                    if (attacks !== want.attacks)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("mismatch: kind %0d square %0d occupancy %h attacks %h, want %h",
                                     want.action, want.square, want.occupancy, attacks,
                                     want.attacks);
                    end
                end
            end
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("FAIL sliding_piece_attack_sets_core");
        $finish;
    end

    initial
    begin : run_test
        logic [5:0] sq;
        int         total_requests;
        add_request(KIND_BISHOP, 6'd0, 64'd0, 1'b0);
        add_request(KIND_ROOK, 6'd0, 64'd0, 1'b0);
        add_request(KIND_QUEEN, 6'd0, '1, 1'b0);
        add_request(KIND_QUEEN, 6'd63, 64'd0, 1'b0);
        add_request(KIND_QUEEN, 6'd63, '1, 1'b0);
        add_request(KIND_BISHOP, 6'd63, 64'd0, 1'b0);
        add_request(KIND_ROOK, 6'd63, '1, 1'b0);
        add_request(KIND_ROOK, 6'd7, '1, 1'b0);
        add_request(KIND_BISHOP, 6'd7, 64'd0, 1'b0);
        add_request(KIND_BISHOP, 6'd56, '1, 1'b0);
        add_request(KIND_QUEEN, 6'd56, 64'd0, 1'b0);
        add_request(KIND_QUEEN, 6'd27, 64'd1 << 27, 1'b0);
        add_request(KIND_QUEEN, 6'd27, ~(64'd1 << 27), 1'b0);
        add_request(KIND_ROOK, 6'd36, 64'd1 << 36, 1'b0);
        add_request(KIND_BISHOP, 6'd36, ~(64'd1 << 36), 1'b0);
        add_request(KIND_NONE, 6'd27, '1, 1'b0);
        add_request(KIND_NONE, 6'd0, 64'd0, 1'b0);
        add_request(KIND_NONE, 6'd63, {$urandom, $urandom}, 1'b0);
        for (int i = 0; i < 6; i++)
        begin
            sq = 6'($urandom_range(0, 63));
            add_request(KIND_QUEEN, sq, random_board(), 1'b0);
        end
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            sq = 6'($urandom_range(0, 63));
            add_request(random_kind(), sq, random_board(), i == 600 || i == 1250);
        end
        total_requests = queued_requests.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (requests_taken < total_requests || pending_attacks.size() != 0);
        repeat (10) @(negedge clk);

        if (failures == 0 && pending_attacks.size() == 0)
            $display("PASS sliding_piece_attack_sets_core");
        else
            $display("FAIL sliding_piece_attack_sets_core");
        $finish;
    end

endmodule
